>>> rtl/core/twpe_pkg.sv
// Shared types and constants of the three-way partition engine.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
`timescale 1ns / 1ps

package twpe_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int ELEM_W   = 32;
  localparam int BASE_W   = 16;
  localparam int POS_W    = 6;
  localparam int LO_W     = 17;
  localparam int HI_W     = 18;
  localparam int CFG_W    = 32;
  localparam int CFG_AW   = 1;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 80;

  localparam logic [CFG_AW-1:0] CFG_PIVOT = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_BASE  = 1'b1;

  // one classified request from the front to the back
  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              last;
    logic              drop;
  } cmd_t;

  // one result as the back hands it out
  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic [LO_W-1:0]   lo;
    logic [HI_W-1:0]   hi;
    logic              ovf;
    logic              last;
  } res_t;

endpackage

>>> rtl/core/twpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module twpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/twpe_front.sv
// Front end: accepts input requests and classifies them (store or drop).
// Uses twpe_pkg for the request type.
`timescale 1ns / 1ps

module twpe_front #(
  parameter int STORE_DEPTH = twpe_pkg::STORE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [twpe_pkg::ELEM_W-1:0] value_i,
  input  logic                        last_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output twpe_pkg::cmd_t              cmd_o
);

  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full;

  assign full    = (cnt_q == CNT_W'(STORE_DEPTH));
  assign ready_o = !q_full_i;
  assign push_o  = valid_i && !q_full_i;

  assign cmd_o.value = value_i;
  assign cmd_o.last  = last_i;
  assign cmd_o.drop  = full;

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (!full) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/core/twpe_queue.sv
// Short FIFO of classified requests between front and back.
// Uses twpe_pkg for the request type.
`timescale 1ns / 1ps

module twpe_queue #(
  parameter int DEPTH = twpe_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  twpe_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output twpe_pkg::cmd_t cmd_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  twpe_pkg::cmd_t   buf_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = buf_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/core/twpe_back.sv
// Back end: loads the element store, runs the three-way partition with
// read/swap/write steps, then emits the store through an output register.
// Uses twpe_pkg and twpe_ram.
`timescale 1ns / 1ps

module twpe_back #(
  parameter int STORE_DEPTH = twpe_pkg::STORE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [twpe_pkg::ELEM_W-1:0] pivot_i,
  input  logic [twpe_pkg::BASE_W-1:0] base_i,
  input  logic                        q_valid_i,
  input  twpe_pkg::cmd_t              q_cmd_i,
  output logic                        q_pop_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output twpe_pkg::res_t              out_res_o
);

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_CMP,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  state_e                        state_q;
  logic [CNT_W-1:0]              cnt_q, n_q, sp_q, lt_q, gt_q, k_q;
  logic [ADDR_W-1:0]             part_q;
  logic [twpe_pkg::ELEM_W-1:0]   val_q;
  logic                          less_q, ovf_q;
  logic [twpe_pkg::LO_W-1:0]     lo_q;
  logic [twpe_pkg::HI_W-1:0]     hi_q;
  logic                          out_valid_q;
  twpe_pkg::res_t                out_res_q;

  logic                          we, re;
  logic [ADDR_W-1:0]             waddr, raddr;
  logic [twpe_pkg::ELEM_W-1:0]   wdata, rdata;
  logic                          is_lt, is_gt, fin, out_free, emit_fire;
  logic [CNT_W-1:0]              gt_m1, n_new;

  assign is_lt     = $signed(rdata) < $signed(pivot_i);
  assign is_gt     = $signed(rdata) > $signed(pivot_i);
  assign gt_m1     = gt_q - CNT_W'(1);
  assign fin       = ((k_q + CNT_W'(1)) == n_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_fire = (state_q == ST_EMIT_OUT) && out_free;
  assign n_new     = q_cmd_i.drop ? cnt_q : cnt_q + CNT_W'(1);
  assign q_pop_o   = (state_q == ST_LOAD) && q_valid_i;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // store port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = part_q;
    raddr = sp_q[ADDR_W-1:0];
    wdata = val_q;
    unique case (state_q)
      ST_LOAD: begin
        we    = q_valid_i && !q_cmd_i.drop;
        waddr = cnt_q[ADDR_W-1:0];
        wdata = q_cmd_i.value;
      end
      ST_RD: begin
        re = 1'b1;
      end
      ST_CMP: begin
        re    = is_lt || is_gt;
        raddr = is_lt ? lt_q[ADDR_W-1:0] : gt_m1[ADDR_W-1:0];
      end
      ST_SWAP_A: begin
        we = 1'b1;
      end
      ST_SWAP_B: begin
        we    = 1'b1;
        waddr = sp_q[ADDR_W-1:0];
        wdata = rdata;
      end
      ST_EMIT_RD: begin
        re    = 1'b1;
        raddr = k_q[ADDR_W-1:0];
      end
      ST_EMIT_OUT: begin
      end
      default: begin
      end
    endcase
  end

  twpe_ram #(
    .WIDTH(twpe_pkg::ELEM_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      sp_q        <= '0;
      lt_q        <= '0;
      gt_q        <= '0;
      k_q         <= '0;
      part_q      <= '0;
      val_q       <= '0;
      less_q      <= 1'b0;
      ovf_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (q_valid_i) begin
            if (q_cmd_i.drop) begin
              ovf_q <= 1'b1;
            end
            if (q_cmd_i.last) begin
              cnt_q <= '0;
              n_q   <= n_new;
              k_q   <= '0;
              if (n_new == CNT_W'(1)) begin
                // a single element is its own equal run
                lo_q    <= twpe_pkg::LO_W'(base_i);
                hi_q    <= twpe_pkg::HI_W'(base_i);
                state_q <= ST_EMIT_RD;
              end else begin
                sp_q    <= '0;
                lt_q    <= '0;
                gt_q    <= n_new;
                state_q <= ST_RD;
              end
            end else begin
              cnt_q <= n_new;
            end
          end
        end
        ST_RD: begin
          if (sp_q < gt_q) begin
            state_q <= ST_CMP;
          end else begin
            lo_q    <= twpe_pkg::LO_W'(base_i) + twpe_pkg::LO_W'(lt_q);
            hi_q    <= twpe_pkg::HI_W'(base_i) + twpe_pkg::HI_W'(gt_q)
                       - twpe_pkg::HI_W'(1);
            state_q <= ST_EMIT_RD;
          end
        end
        ST_CMP: begin
          val_q  <= rdata;
          less_q <= is_lt;
          if (is_lt) begin
            part_q  <= lt_q[ADDR_W-1:0];
            lt_q    <= lt_q + CNT_W'(1);
            state_q <= ST_SWAP_A;
          end else if (is_gt) begin
            part_q  <= gt_m1[ADDR_W-1:0];
            gt_q    <= gt_m1;
            state_q <= ST_SWAP_A;
          end else begin
            sp_q    <= sp_q + CNT_W'(1);
            state_q <= ST_RD;
          end
        end
        ST_SWAP_A: begin
          state_q <= ST_SWAP_B;
        end
        ST_SWAP_B: begin
          if (less_q) begin
            sp_q <= sp_q + CNT_W'(1);
          end
          state_q <= ST_RD;
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (out_free) begin
            out_res_q.value <= rdata;
            out_res_q.pos   <= twpe_pkg::POS_W'(k_q);
            out_res_q.lo    <= fin ? lo_q : '0;
            out_res_q.hi    <= fin ? hi_q : '0;
            out_res_q.ovf   <= ovf_q;
            out_res_q.last  <= fin;
            k_q             <= k_q + CNT_W'(1);
            if (fin) begin
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/three_way_partition_engine.sv
// Three-way partition engine: top level with config registers and stream ports.
// Load pops requests from the queue; partition reads and compares each element, moving
// a non-equal one through the swap states (store port limits it); emit reads each
// result, held while stalled. One run at a time in the back; the front takes requests
// while the queue has room. Reset (rst_ni low, async): registers and counters cleared.
`timescale 1ns / 1ps

module three_way_partition_engine #(
  parameter int STORE_DEPTH = twpe_pkg::STORE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [twpe_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [twpe_pkg::CFG_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [twpe_pkg::S_DATA_W-1:0] s_axis_tdata,  // [31:0] element_value
  input  logic                          s_axis_tlast,  // is_last_in
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] out_value, [37:32] out_position, [54:38] equal_low,
  // [72:55] equal_high, [73] overflow, [79:74] zero
  output logic [twpe_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast   // is_last_out
);

  logic [twpe_pkg::ELEM_W-1:0] pivot_q;
  logic [twpe_pkg::BASE_W-1:0] base_q;

  logic           push, q_full, q_valid, q_pop;
  twpe_pkg::cmd_t push_cmd, head_cmd;
  twpe_pkg::res_t res;

  // config registers; write them only while idle (the block does not enforce this)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q <= '0;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        twpe_pkg::CFG_PIVOT: pivot_q <= cfg_wdata_i[twpe_pkg::ELEM_W-1:0];
        twpe_pkg::CFG_BASE:  base_q  <= cfg_wdata_i[twpe_pkg::BASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: take requests, mark the ones that would overrun the store
  twpe_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .value_i (s_axis_tdata[twpe_pkg::ELEM_W-1:0]),
    .last_i  (s_axis_tlast),
    .q_full_i(q_full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // decoupling queue
  twpe_queue #(
    .DEPTH(twpe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  // back: store, partition, emit
  twpe_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pivot_i    (pivot_q),
    .base_i     (base_q),
    .q_valid_i  (q_valid),
    .q_cmd_i    (head_cmd),
    .q_pop_o    (q_pop),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_res_o  (res)
  );

  assign m_axis_tdata = {6'b0, res.ovf, res.hi, res.lo, res.pos, res.value};
  assign m_axis_tlast = res.last;

endmodule

>>> rtl/core/twpe_checker.sv
// Port-level checks of the three-way partition engine, bound to the top level.
// No package dependencies.
`timescale 1ns / 1ps

module twpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // range bounds only on the last result of a run
  a_bounds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[72:38] == 35'd0)
    else $error("range bounds on a non-final result");

  // positions count up inside a run
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
    !m_axis_tvalid || m_axis_tdata[37:32] == $past(m_axis_tdata[37:32]) + 6'd1)
    else $error("result position skipped");

  // a run restarts at position zero
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
    !m_axis_tvalid || m_axis_tdata[37:32] == 6'd0)
    else $error("run did not restart at position zero");

  // equal run is never shorter than empty
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
    $signed(m_axis_tdata[72:55]) >= $signed({1'b0, m_axis_tdata[54:38]}) - 18'sd1)
    else $error("equal run bounds inverted");

endmodule

bind three_way_partition_engine twpe_checker u_twpe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
